[hdl/wfs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfs_pkg
// Shared types, register codes and constant functions of the wavefold
// saturator: configuration record, sine table entries, stereo reciprocals.
// ----------------------------------------------------------------------------
package wfs_pkg;

  typedef enum logic [2:0] {
    CFG_CHANNELS     = 3'd0,
    CFG_FREQ_BASE    = 3'd1,
    CFG_FATNESS      = 3'd2,
    CFG_DRIVE_MIX    = 3'd3,
    CFG_DRY_MIX      = 3'd4,
    CFG_STEREO_WIDTH = 3'd5,
    CFG_OUTPUT_GAIN  = 3'd6,
    CFG_NORM_GAIN    = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [3:0]         channels_in_use;
    logic [16:0]        freq_base;
    logic signed [15:0] fatness;
    logic [16:0]        drive_mix;
    logic [16:0]        dry_mix;
    logic [16:0]        stereo_width;
    logic [16:0]        output_gain;
    logic [16:0]        norm_gain;
  } cfg_t;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam longint      ONE_Q30     = 64'sd1073741824;
  localparam logic [16:0] UNIT_Q16    = 17'd65536;

  function automatic logic [16:0] sat_unit(input logic [16:0] v);
    return (v > UNIT_Q16) ? UNIT_Q16 : v;
  endfunction

  // ceil(2^32 / (5*d)), exact floor division for numerators below 2^24
  function automatic logic [29:0] stereo_recip(input logic [3:0] d);
    logic [29:0] m;
    case (d)
      4'd1:    m = 30'(((64'd1 << 32) + 64'd4) / 64'd5);
      4'd2:    m = 30'(((64'd1 << 32) + 64'd9) / 64'd10);
      4'd3:    m = 30'(((64'd1 << 32) + 64'd14) / 64'd15);
      4'd4:    m = 30'(((64'd1 << 32) + 64'd19) / 64'd20);
      4'd5:    m = 30'(((64'd1 << 32) + 64'd24) / 64'd25);
      4'd6:    m = 30'(((64'd1 << 32) + 64'd29) / 64'd30);
      4'd7:    m = 30'(((64'd1 << 32) + 64'd34) / 64'd35);
      4'd8:    m = 30'(((64'd1 << 32) + 64'd39) / 64'd40);
      4'd9:    m = 30'(((64'd1 << 32) + 64'd44) / 64'd45);
      4'd10:   m = 30'(((64'd1 << 32) + 64'd49) / 64'd50);
      4'd11:   m = 30'(((64'd1 << 32) + 64'd54) / 64'd55);
      4'd12:   m = 30'(((64'd1 << 32) + 64'd59) / 64'd60);
      4'd13:   m = 30'(((64'd1 << 32) + 64'd64) / 64'd65);
      4'd14:   m = 30'(((64'd1 << 32) + 64'd69) / 64'd70);
      4'd15:   m = 30'(((64'd1 << 32) + 64'd74) / 64'd75);
      default: m = 30'd0;
    endcase
    return m;
  endfunction

  // quarter-wave sine entry k of a 2^tb table, Q1.30, taylor series through x^15
  function automatic logic [30:0] sine_entry(input int unsigned k, input int unsigned tb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      s;
    x = (64'(k) * HALF_PI_Q30) >> tb;
    x2 = (x * x) >> 30;
    term = x;
    s = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        s = s - longint'(term);
      end else begin
        s = s + longint'(term);
      end
    end
    if (s < 0) s = 0;
    if (s > ONE_Q30) s = ONE_Q30;
    return 31'(s);
  endfunction

endpackage
`default_nettype wire

[hdl/wfs_sine_rom.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfs_sine_rom
// Quarter-wave sine table with two registered read ports, entry and next
// entry, for linear interpolation.
// ----------------------------------------------------------------------------
module wfs_sine_rom #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [SINE_TABLE_BITS:0] addr,
  output logic [30:0]              rd_a,
  output logic [30:0]              rd_b
);
  import wfs_pkg::*;

  localparam int AW    = SINE_TABLE_BITS + 1;
  localparam int DEPTH = (1 << SINE_TABLE_BITS) + 1;

  logic [30:0]   rom [DEPTH];
  logic [AW-1:0] addr_b;

  for (genvar k = 0; k < DEPTH; k++) begin : g_rom
    assign rom[k] = sine_entry(k, SINE_TABLE_BITS);
  end

  assign addr_b = (addr == AW'(DEPTH - 1)) ? addr : addr + AW'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      rd_a <= rom[addr];
      rd_b <= rom[addr_b];
    end
  end

endmodule
`default_nettype wire

[hdl/wfs_pregain.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfs_pregain
// Channel frequency with stereo spread, cosine lookup and the pre-gain
// 100 - 99cos(freq*pi/2), six pipeline stages.
// ----------------------------------------------------------------------------
module wfs_pregain #(
  parameter int MAX_CHANNELS    = 8,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic          clk,
  input  logic [5:0]    adv,
  input  wfs_pkg::cfg_t cfg,
  input  logic [2:0]    channel_index,
  output logic [23:0]   gain
);
  import wfs_pkg::*;

  localparam int SC = 16 - SINE_TABLE_BITS;

  // stage 0
  logic [4:0]         cnt_lim;
  logic [3:0]         d;
  logic signed [5:0]  k;
  logic signed [23:0] p;
  logic [22:0]        s0_pabs;
  logic               s0_neg;
  logic               s0_multi;
  logic [29:0]        s0_recip;

  always_comb begin
    cnt_lim = ({1'b0, cfg.channels_in_use} > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS)
            : {1'b0, cfg.channels_in_use};
    d = 4'(cnt_lim - 5'd1);
    k = $signed({2'b00, channel_index, 1'b0}) - $signed({2'b00, d});
    p = $signed({1'b0, cfg.stereo_width}) * k;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_pabs  <= p[23] ? 23'(-p) : 23'(p);
      s0_neg   <= p[23];
      s0_multi <= cnt_lim > 5'd1;
      s0_recip <= stereo_recip(d);
    end
  end

  // stage 1
  logic [52:0] qprod;
  logic [20:0] s1_q;
  logic        s1_neg;
  logic        s1_multi;

  assign qprod = 53'(s0_pabs) * 53'(s0_recip);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_q     <= qprod[52:32];
      s1_neg   <= s0_neg;
      s1_multi <= s0_multi;
    end
  end

  // stage 2
  logic signed [22:0] term;
  logic signed [22:0] freq;
  logic [16:0]        freq_c;
  logic [16:0]        s2_rr;

  always_comb begin
    if (!s1_multi) begin
      term = '0;
    end else if (s1_neg) begin
      term = -$signed({2'b00, s1_q});
    end else begin
      term = $signed({2'b00, s1_q});
    end
    freq = $signed({6'b0, cfg.freq_base}) + term;
    if (freq < 0) begin
      freq_c = 17'd0;
    end else if (freq > $signed({6'b0, UNIT_Q16})) begin
      freq_c = UNIT_Q16;
    end else begin
      freq_c = freq[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_rr <= UNIT_Q16 - freq_c;
    end
  end

  // stage 3
  logic [30:0]   rd_a;
  logic [30:0]   rd_b;
  logic [SC-1:0] s3_fr;

  wfs_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom (
    .clk  (clk),
    .en   (adv[3]),
    .addr (s2_rr[16:SC]),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_fr <= s2_rr[SC-1:0];
    end
  end

  // stage 4
  logic signed [31:0]   diff;
  logic signed [SC+32:0] s4_prod;
  logic [30:0]          s4_a;

  assign diff = $signed({1'b0, rd_b}) - $signed({1'b0, rd_a});

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_prod <= diff * $signed({1'b0, s3_fr});
      s4_a    <= rd_a;
    end
  end

  // stage 5
  logic signed [31:0] c;
  logic signed [37:0] t;

  always_comb begin
    c = $signed({1'b0, s4_a}) + $signed(s4_prod[SC+31:SC]);
    t = 38'sd107374182400 - 38'sd99 * $signed({{6{c[31]}}, c});
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      gain <= t[37:14];
    end
  end

endmodule
`default_nettype wire

[hdl/wfs_shaper.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfs_shaper
// Pre-gain, triangle fold and hard clip mix, sine lookup and fatness
// weighted soft saturation, nine pipeline stages.
// ----------------------------------------------------------------------------
module wfs_shaper #(
  parameter int SAMPLE_BITS     = 24,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                          clk,
  input  logic [8:0]                    adv,
  input  wfs_pkg::cfg_t                 cfg,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic [23:0]                   gain,
  output logic signed [SAMPLE_BITS+7:0] wet
);
  import wfs_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int F  = SB - 1;
  localparam int SS = F - SINE_TABLE_BITS;
  localparam int WS = SB + 9;
  localparam int FW = SB + 2;
  localparam int DW = SB + 3;
  localparam int WW = SB + 8;
  localparam int SH = (F <= 30) ? (30 - F) : (F - 30);

  localparam logic [FW-1:0]        K1        = FW'(1) << F;
  localparam logic [FW-1:0]        K2        = K1 << 1;
  localparam logic [FW-1:0]        K3        = K1 + K2;
  localparam logic [FW-1:0]        K4        = K1 << 2;
  localparam logic [F:0]           R1        = (F + 1)'(1) << F;
  localparam logic signed [WS-1:0] ONE_S     = WS'(1) << F;
  localparam logic signed [WS-1:0] NEG_ONE_S = -ONE_S;

  // stage 6
  logic signed [SB+24:0] xg;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      xg <= x * $signed({1'b0, gain});
    end
  end

  // stage 7
  logic signed [WS-1:0] smpl;
  logic signed [WS-1:0] smpl_abs;
  logic [FW-1:0]        mag;
  logic [FW-1:0]        fold_u;
  logic [FW-1:0]        clip_u;
  logic signed [FW-1:0] s7_clip;
  logic signed [FW-1:0] s7_fold;

  always_comb begin
    smpl = $signed(xg[SB+24:16]);
    smpl_abs = smpl[WS-1] ? -smpl : smpl;
    mag = smpl_abs[F+1:0];
    if (mag > K3) begin
      fold_u = mag - K4;
    end else if (mag > K1) begin
      fold_u = K2 - mag;
    end else begin
      fold_u = mag;
    end
    if (smpl[WS-1] || smpl == 0) fold_u = -fold_u;
    if (smpl > ONE_S) begin
      clip_u = FW'(ONE_S);
    end else if (smpl < NEG_ONE_S) begin
      clip_u = FW'(NEG_ONE_S);
    end else begin
      clip_u = FW'(smpl);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s7_clip <= $signed(clip_u);
      s7_fold <= $signed(fold_u);
    end
  end

  // stage 8
  logic [16:0]           dm;
  logic [16:0]           idm;
  logic signed [FW+17:0] s8_pc;
  logic signed [FW+17:0] s8_pf;

  assign dm  = sat_unit(cfg.drive_mix);
  assign idm = UNIT_Q16 - dm;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s8_pc <= s7_clip * $signed({1'b0, dm});
      s8_pf <= s7_fold * $signed({1'b0, idm});
    end
  end

  // stage 9
  logic signed [FW+18:0] msum;
  logic signed [FW-1:0]  smpl2;
  logic [F+1:0]          u;
  logic [F:0]            rr;
  logic [F:0]            s9_rr;
  logic                  s9_neg;
  logic signed [FW-1:0]  s9_sm;

  always_comb begin
    msum = s8_pc + s8_pf;
    smpl2 = $signed(msum[FW+15:16]);
    u = smpl2[F+1:0];
    rr = u[F] ? (R1 - {1'b0, u[F-1:0]}) : {1'b0, u[F-1:0]};
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s9_rr  <= rr;
      s9_neg <= u[F+1];
      s9_sm  <= smpl2;
    end
  end

  // stage 10
  logic [30:0]          rd_a;
  logic [30:0]          rd_b;
  logic [SS-1:0]        s10_fr;
  logic                 s10_neg;
  logic signed [FW-1:0] s10_sm;

  wfs_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom (
    .clk  (clk),
    .en   (adv[4]),
    .addr (s9_rr[F:SS]),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s10_fr  <= s9_rr[SS-1:0];
      s10_neg <= s9_neg;
      s10_sm  <= s9_sm;
    end
  end

  // stage 11
  logic signed [31:0]    sdiff;
  logic signed [SS+32:0] s11_prod;
  logic [30:0]           s11_a;
  logic                  s11_neg;
  logic signed [FW-1:0]  s11_sm;

  assign sdiff = $signed({1'b0, rd_b}) - $signed({1'b0, rd_a});

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s11_prod <= sdiff * $signed({1'b0, s10_fr});
      s11_a    <= rd_a;
      s11_neg  <= s10_neg;
      s11_sm   <= s10_sm;
    end
  end

  // stage 12
  logic signed [31:0]   v;
  logic signed [32:0]   ve;
  logic signed [32:0]   vs;
  logic signed [32:0]   sn;
  logic signed [DW-1:0] s12_diff;
  logic signed [FW-1:0] s12_sm;

  always_comb begin
    v = $signed({1'b0, s11_a}) + $signed(s11_prod[SS+31:SS]);
    ve = 33'(v);
    vs = s11_neg ? -ve : ve;
    if (F <= 30) begin
      sn = vs >>> SH;
    end else begin
      sn = vs <<< SH;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s12_diff <= DW'(sn) - DW'(s11_sm);
      s12_sm   <= s11_sm;
    end
  end

  // stage 13
  logic signed [DW+15:0] s13_prod;
  logic signed [FW-1:0]  s13_sm;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s13_prod <= s12_diff * cfg.fatness;
      s13_sm   <= s12_sm;
    end
  end

  // stage 14
  always_ff @(posedge clk) begin
    if (adv[8]) begin
      wet <= WW'(s13_sm) + WW'(s13_prod >>> 10);
    end
  end

endmodule
`default_nettype wire

[hdl/wfs_post.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wfs_post
// Dry blend, output gain, normalization gain and final saturation to the
// sample range, five pipeline stages.
// ----------------------------------------------------------------------------
module wfs_post #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic [4:0]                    adv,
  input  wfs_pkg::cfg_t                 cfg,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic signed [SAMPLE_BITS+7:0] wet,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);
  import wfs_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int F  = SB - 1;
  localparam int WW = SB + 8;

  localparam logic signed [WW-1:0] YONE = WW'(1) << F;
  localparam logic signed [WW-1:0] YMAX = YONE - WW'(1);
  localparam logic signed [WW-1:0] YMIN = -YONE;

  logic [16:0] dry;
  logic [16:0] idry;

  assign dry  = sat_unit(cfg.dry_mix);
  assign idry = UNIT_Q16 - dry;

  // stage 15
  logic signed [WW+17:0] s15_pw;
  logic signed [SB+17:0] s15_px;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s15_pw <= wet * $signed({1'b0, idry});
      s15_px <= x * $signed({1'b0, dry});
    end
  end

  // stage 16
  logic signed [WW+18:0] ysum;
  logic signed [WW-1:0]  s16_y;

  assign ysum = s15_pw + s15_px;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s16_y <= $signed(ysum[WW+15:16]);
    end
  end

  // stage 17
  logic signed [WW+17:0] s17_p;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s17_p <= s16_y * $signed({1'b0, sat_unit(cfg.output_gain)});
    end
  end

  // stage 18
  logic signed [WW-1:0]  y2;
  logic signed [WW+17:0] s18_p;

  assign y2 = $signed(s17_p[WW+15:16]);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s18_p <= y2 * $signed({1'b0, sat_unit(cfg.norm_gain)});
    end
  end

  // stage 19
  logic signed [WW-1:0] y3;
  logic signed [WW-1:0] yc;

  always_comb begin
    y3 = $signed(s18_p[WW+15:16]);
    if (y3 > YMAX) begin
      yc = YMAX;
    end else if (y3 < YMIN) begin
      yc = YMIN;
    end else begin
      yc = y3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      sample_out <= SB'(yc);
    end
  end

endmodule
`default_nettype wire

[hdl/wavefold_saturator_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wavefold_saturator_top
// Throughput: one sample per cycle while the output is not stalled; 20-stage multiply pipeline.
// Stages advance independently, so bubbles close up while the output stalls.
// Reset clears all stage valid bits and loads register defaults; the sine
// tables are constant, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module wavefold_saturator_top #(
  parameter int MAX_CHANNELS    = 8,
  parameter int SAMPLE_BITS     = 24,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic [2:0]                    channel_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [16:0]                   cfg_data
);
  import wfs_pkg::*;

  localparam int STG = 20;
  localparam int XD  = 15;

  cfg_t cfg;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channels_in_use <= 4'd2;
      cfg.freq_base       <= 17'd20972;
      cfg.fatness         <= 16'sd0;
      cfg.drive_mix       <= 17'd0;
      cfg.dry_mix         <= 17'd0;
      cfg.stereo_width    <= 17'd24248;
      cfg.output_gain     <= 17'd26214;
      cfg.norm_gain       <= 17'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_CHANNELS:     cfg.channels_in_use <= cfg_data[3:0];
        CFG_FREQ_BASE:    cfg.freq_base       <= cfg_data;
        CFG_FATNESS:      cfg.fatness         <= $signed(cfg_data[15:0]);
        CFG_DRIVE_MIX:    cfg.drive_mix       <= cfg_data;
        CFG_DRY_MIX:      cfg.dry_mix         <= cfg_data;
        CFG_STEREO_WIDTH: cfg.stereo_width    <= cfg_data;
        CFG_OUTPUT_GAIN:  cfg.output_gain     <= cfg_data;
        CFG_NORM_GAIN:    cfg.norm_gain       <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [STG-1:0] v;
  logic [STG-1:0] adv;

  assign adv[STG-1] = !v[STG-1] || out_ready;
  for (genvar g = 0; g < STG - 1; g++) begin : g_adv
    assign adv[g] = !v[g] || adv[g+1];
  end

  assign in_ready  = adv[0];
  assign out_valid = v[STG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int i = 1; i < STG; i++) begin
        if (adv[i]) v[i] <= v[i-1];
      end
    end
  end

  // dry sample delay line
  logic signed [SAMPLE_BITS-1:0] x_pipe [XD];

  always_ff @(posedge clk) begin
    if (adv[0]) x_pipe[0] <= sample_in;
    for (int i = 1; i < XD; i++) begin
      if (adv[i]) x_pipe[i] <= x_pipe[i-1];
    end
  end

  logic [23:0]                   gain;
  logic signed [SAMPLE_BITS+7:0] wet;

  wfs_pregain #(
    .MAX_CHANNELS    (MAX_CHANNELS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_pregain (
    .clk           (clk),
    .adv           (adv[5:0]),
    .cfg           (cfg),
    .channel_index (channel_index),
    .gain          (gain)
  );

  wfs_shaper #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_shaper (
    .clk  (clk),
    .adv  (adv[14:6]),
    .cfg  (cfg),
    .x    (x_pipe[5]),
    .gain (gain),
    .wet  (wet)
  );

  wfs_post #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_post (
    .clk        (clk),
    .adv        (adv[19:15]),
    .cfg        (cfg),
    .x          (x_pipe[14]),
    .wet        (wet),
    .sample_out (sample_out)
  );

  a_ready_needs_room: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (out_ready || !(&v)))
    else $error("input ready while every stage is full and output stalled");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !(out_valid && out_ready))
    |=> ($countones(v) == $past($countones(v)) + 1))
    else $error("accepted sample not tracked in pipeline");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !(in_valid && in_ready))
    |=> ($countones(v) + 1 == $past($countones(v))))
    else $error("delivered sample not retired from pipeline");

endmodule
`default_nettype wire
